// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;
    localparam int NUM_OUT_BITS = 34;
    localparam int DEN_OUT_BITS = 33;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic start;
    } t_div_ctl;
endpackage

// ===== rtl/rational_arith_unit.sv =====
// Top level: sequencer around one multiplier and one shared divider.
// Channel | Signals                                    | Direction
// input   | i_valid/o_ready, op, a/b num/den           | in
// output  | o_valid/i_ready, res_num, res_den, error   | out
// Result follows the multiply states, the gcd divisions and the two divisions by the gcd.
// Add and subtract use a third product; error and zero-numerator items skip the divider.
// Gcd Euclid steps dominate; each step is one full pass of the bit-serial divider.
// Reset clears the sequencer; the result register holds until taken.
// A full result register holds the sequencer in its output state; input is ready only in idle.
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_op,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [NUM_OUT_BITS-1:0]  o_res_num,
    output logic [DEN_OUT_BITS-1:0]         o_res_den,
    output logic                            o_error
);
    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW;
    localparam int MW = PW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_GCD, S_GWAIT, S_DNUM, S_WNUM,
        S_DDEN, S_WDEN, S_OUT
    } t_state;

    t_state        r_state;
    t_op           r_op;
    logic [OW-1:0] r_an, r_ad, r_bn, r_bd;
    logic          r_san, r_sad, r_sbn, r_sbd;
    logic [PW-1:0] r_p0;
    logic [MW-1:0] r_nm, r_dm, r_x, r_y, r_g, r_rn;
    logic          r_nneg, r_dneg;
    logic          r_valid, r_err;
    logic signed [NUM_OUT_BITS-1:0] r_onum;
    logic [DEN_OUT_BITS-1:0] r_oden;
    logic signed [NUM_OUT_BITS-1:0] r_res_num;
    logic [DEN_OUT_BITS-1:0] r_res_den;
    logic          r_res_err;

    logic [OW-1:0] n_ma, n_mb;
    logic [PW-1:0] n_prod;
    t_div_ctl      n_ctl;
    logic [MW-1:0] n_dvd, n_dvs;
    logic          d_done;
    logic [MW-1:0] d_q, d_r;

    function automatic logic [OW-1:0] f_mag(input logic [OW-1:0] v);
        return v[OW-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        case (r_state)
            S_MUL0:  begin n_ma = r_an; n_mb = (r_op == OP_DIV) ? r_bd : r_bd; end
            S_MUL1:  begin n_ma = r_ad; n_mb = (r_op == OP_DIV) ? r_bn : r_bd; end
            S_MUL2:  begin n_ma = r_ad; n_mb = r_bn; end
            default: begin n_ma = r_an; n_mb = r_bn; end
        endcase
    end
    always_comb begin
        if (r_state == S_MUL0 && r_op == OP_MUL) n_prod = r_an * r_bn;
        else n_prod = n_ma * n_mb;
    end

    always_comb begin
        n_ctl.start = (r_state == S_GCD) || (r_state == S_DNUM) || (r_state == S_DDEN);
        case (r_state)
            S_DNUM:  begin n_dvd = r_nm; n_dvs = r_g; end
            S_DDEN:  begin n_dvd = r_dm; n_dvs = r_g; end
            default: begin n_dvd = r_x;  n_dvs = r_y; end
        endcase
    end

    rau_divider #(.W(MW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (n_ctl),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_done     (d_done),
        .o_quot     (d_q),
        .o_rem      (d_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_valid || i_ready)) r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op  <= t_op'(i_op);
                    r_an  <= f_mag(i_a_num); r_san <= i_a_num[OW-1];
                    r_ad  <= f_mag(i_a_den); r_sad <= i_a_den[OW-1];
                    r_bn  <= f_mag(i_b_num); r_sbn <= i_b_num[OW-1];
                    r_bd  <= f_mag(i_b_den); r_sbd <= i_b_den[OW-1];
                    r_state <= S_MUL0;
                end
                S_MUL0: begin
                    r_p0 <= n_prod;
                    if (r_ad == '0 || r_bd == '0 || (r_op == OP_DIV && r_bn == '0)) begin
                        r_err <= 1'b1; r_onum <= '0; r_oden <= '0; r_state <= S_OUT;
                    end else begin
                        r_err <= 1'b0; r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_dneg <= (r_op == OP_DIV) ? (r_sad ^ r_sbn) : (r_sad ^ r_sbd);
                    r_dm <= MW'(n_prod);
                    if (r_op == OP_ADD || r_op == OP_SUB) r_state <= S_MUL2;
                    else begin
                        r_nm   <= MW'(r_p0);
                        r_nneg <= (r_op == OP_DIV) ? (r_san ^ r_sbd) : (r_san ^ r_sbn);
                        r_state <= S_SUM;
                    end
                end
                S_MUL2: begin
                    r_state <= S_SUM;
                    if (r_san ^ r_sbd ^ ((r_sad ^ r_sbn ^ (r_op == OP_SUB)) ^ (r_san ^ r_sbd))
                        == (r_san ^ r_sbd)) begin
                        r_nm <= MW'(r_p0) + MW'(n_prod);
                        r_nneg <= r_san ^ r_sbd;
                    end else if (r_p0 >= n_prod) begin
                        r_nm <= MW'(r_p0 - n_prod);
                        r_nneg <= r_san ^ r_sbd;
                    end else begin
                        r_nm <= MW'(n_prod - r_p0);
                        r_nneg <= r_sad ^ r_sbn ^ (r_op == OP_SUB);
                    end
                end
                S_SUM: begin
                    r_x <= r_nm; r_y <= r_dm;
                    if (r_nm == '0) begin
                        r_onum <= '0; r_oden <= '0; r_state <= S_OUT;
                    end else r_state <= S_GCD;
                end
                S_GCD: r_state <= S_GWAIT;
                S_GWAIT: if (d_done) begin
                    if (d_r == '0) begin
                        r_g <= r_y; r_state <= S_DNUM;
                    end else begin
                        r_x <= r_y; r_y <= d_r; r_state <= S_GCD;
                    end
                end
                S_DNUM: r_state <= S_WNUM;
                S_WNUM: if (d_done) begin r_rn <= d_q; r_state <= S_DDEN; end
                S_DDEN: r_state <= S_WDEN;
                S_WDEN: if (d_done) begin
                    r_onum <= (r_nneg ^ r_dneg) ? NUM_OUT_BITS'(~r_rn + 1'b1)
                                                : NUM_OUT_BITS'(r_rn);
                    r_oden <= DEN_OUT_BITS'(d_q);
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_valid || i_ready) begin
                    r_res_num <= r_onum;
                    r_res_den <= r_oden;
                    r_res_err <= r_err;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_valid;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_error   = r_res_err;
endmodule

// ===== rtl/rau_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, giving quotient and remainder.
module rau_divider
    import rau_pkg::*;
#(
    parameter int W = 66
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_div_ctl     i_ctl,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    n_sh;
    logic [W:0]    n_diff;

    assign n_sh   = {r_r, r_q[W-1]};
    assign n_diff = n_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (!n_diff[W]) begin
                    r_r <= n_diff[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= n_sh[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_port_checks
    import rau_pkg::*;
(
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic signed [NUM_OUT_BITS-1:0] o_res_num,
    input logic [DEN_OUT_BITS-1:0]        o_res_den,
    input logic                           o_error
);
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_res_num == '0 && o_res_den == '0) else $error("err");
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res_den == '0 |-> o_res_num == '0) else $error("den");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_num)) else $error("hold");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("busy");
endmodule

bind rational_arith_unit rau_port_checks u_chk (.*);
